/* design/gbd_pkg.sv */
// ----------------------------------------------------------------------------
// gbd_pkg
// Shared types and constants for the grapheme cluster boundary detector.
// ----------------------------------------------------------------------------
package gbd_pkg;

  typedef enum logic [3:0] {
    CL_OTHER       = 4'd0,
    CL_CR          = 4'd1,
    CL_LF          = 4'd2,
    CL_CONTROL     = 4'd3,
    CL_EXTEND      = 4'd4,
    CL_ZWJ         = 4'd5,
    CL_RI          = 4'd6,
    CL_PREPEND     = 4'd7,
    CL_SPACINGMARK = 4'd8,
    CL_L           = 4'd9,
    CL_V           = 4'd10,
    CL_T           = 4'd11,
    CL_LV          = 4'd12,
    CL_LVT         = 4'd13
  } gb_class_t;

  typedef enum logic [1:0] {
    CJ_NONE      = 2'd0,
    CJ_LINKER    = 2'd1,
    CJ_CONSONANT = 2'd2,
    CJ_EXTEND    = 2'd3
  } cj_class_t;

  localparam int CP_W = 21;

  localparam logic [CP_W-1:0] CP_LF       = 21'h0A;
  localparam logic [CP_W-1:0] CP_CR       = 21'h0D;
  localparam logic [CP_W-1:0] CP_CTRL_END = 21'h20;
  localparam logic [CP_W-1:0] CP_DEL      = 21'h7F;
  localparam logic [CP_W-1:0] CP_NON_ASCII = 21'h80;

  // classified item handed from the classifier to the rule engine
  typedef struct packed {
    gb_class_t cls;
    cj_class_t cj;
    logic      pict;
    logic      printable;  // unescaped 0x20..0x7E
  } gbd_item_t;

  function automatic logic is_ctl(input gb_class_t c);
    return (c == CL_CONTROL) || (c == CL_CR) || (c == CL_LF);
  endfunction

endpackage

/* design/gbd_classify.sv */
// ----------------------------------------------------------------------------
// gbd_classify
// Derives the effective break class, conjunct class and pictographic flag of
// one item; ASCII and escapes are classified here, the rest from the table.
// ----------------------------------------------------------------------------
module gbd_classify import gbd_pkg::*; (
  input  logic [CP_W-1:0] code_point,
  input  logic            is_escape,
  input  logic [3:0]      break_class,
  input  logic [1:0]      conjunct_class,
  input  logic            pictographic,
  output gbd_item_t       item
);

  logic ascii;

  assign ascii = (code_point < CP_NON_ASCII);

  always_comb begin
    item.printable = !is_escape && (code_point >= CP_CTRL_END) && (code_point < CP_DEL);
    if (is_escape) begin
      item.cls  = CL_CONTROL;
      item.cj   = CJ_NONE;
      item.pict = 1'b0;
    end else if (ascii) begin
      if (code_point == CP_CR) begin
        item.cls = CL_CR;
      end else if (code_point == CP_LF) begin
        item.cls = CL_LF;
      end else if ((code_point < CP_CTRL_END) || (code_point == CP_DEL)) begin
        item.cls = CL_CONTROL;
      end else begin
        item.cls = CL_OTHER;
      end
      item.cj   = CJ_NONE;
      item.pict = 1'b0;
    end else begin
      // codes above LVT mean nothing and fall back to Other
      item.cls  = (break_class > 4'(CL_LVT)) ? CL_OTHER : gb_class_t'(break_class);
      item.cj   = cj_class_t'(conjunct_class);
      item.pict = pictographic;
    end
  end

endmodule

/* design/gbd_rules.sv */
// ----------------------------------------------------------------------------
// gbd_rules
// Boundary rules GB1..GB999 and the carried state: previous class, regional
// indicator parity, pictograph/ZWJ chain and conjunct progress.
// ----------------------------------------------------------------------------
module gbd_rules import gbd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  logic      start_of_text,
  input  gbd_item_t item,
  output logic      boundary
);

  gb_class_t previous_class, previous_class_next;
  logic seen_any, seen_any_next;
  logic regional_odd, regional_odd_next;
  logic pictograph_chain, pictograph_chain_next;
  logic conjunct_consonant_seen, conjunct_consonant_seen_next;
  logic conjunct_linker_seen, conjunct_linker_seen_next;

  // state as seen by this item, after an optional restart
  gb_class_t p;
  logic      sa, ro, pc, cc, cl;
  logic      fast;
  logic      rule_b;
  gb_class_t c;

  always_comb begin
    p  = start_of_text ? CL_OTHER : previous_class;
    sa = !start_of_text && seen_any;
    ro = !start_of_text && regional_odd;
    pc = !start_of_text && pictograph_chain;
    cc = !start_of_text && conjunct_consonant_seen;
    cl = !start_of_text && conjunct_linker_seen;
    c  = item.cls;

    fast = item.printable && (p == CL_OTHER);

    if (!sa) begin
      rule_b = 1'b1;
    end else if (p == CL_CR && c == CL_LF) begin
      rule_b = 1'b0;
    end else if (is_ctl(p) || is_ctl(c)) begin
      rule_b = 1'b1;
    end else if (p == CL_L &&
                 (c == CL_L || c == CL_V || c == CL_LV || c == CL_LVT)) begin
      rule_b = 1'b0;
    end else if ((p == CL_LV || p == CL_V) && (c == CL_V || c == CL_T)) begin
      rule_b = 1'b0;
    end else if ((p == CL_LVT || p == CL_T) && c == CL_T) begin
      rule_b = 1'b0;
    end else if (c == CL_EXTEND || c == CL_ZWJ || c == CL_SPACINGMARK) begin
      rule_b = 1'b0;
    end else if (p == CL_PREPEND) begin
      rule_b = 1'b0;
    end else if (item.cj == CJ_CONSONANT && cc && cl) begin
      rule_b = 1'b0;
    end else if (p == CL_ZWJ && pc && item.pict) begin
      rule_b = 1'b0;
    end else if (c == CL_RI && ro) begin
      rule_b = 1'b0;
    end else begin
      rule_b = 1'b1;
    end

    boundary = fast || rule_b;

    seen_any_next = 1'b1;
    if (fast) begin
      previous_class_next          = p;
      regional_odd_next            = 1'b0;
      pictograph_chain_next        = 1'b0;
      conjunct_consonant_seen_next = 1'b0;
      conjunct_linker_seen_next    = 1'b0;
    end else begin
      previous_class_next = c;
      regional_odd_next   = (c == CL_RI) ? !ro : 1'b0;

      if (item.pict) begin
        pictograph_chain_next = 1'b1;
      end else if (c == CL_EXTEND && p != CL_ZWJ) begin
        pictograph_chain_next = pc;
      end else if (c == CL_ZWJ && p != CL_ZWJ) begin
        pictograph_chain_next = pc;
      end else begin
        pictograph_chain_next = 1'b0;
      end

      conjunct_consonant_seen_next = cc;
      conjunct_linker_seen_next    = cl;
      case (item.cj)
        CJ_CONSONANT: begin
          conjunct_consonant_seen_next = 1'b1;
          conjunct_linker_seen_next    = 1'b0;
        end
        CJ_LINKER: begin
          if (cc) begin
            conjunct_linker_seen_next = 1'b1;
          end else begin
            conjunct_consonant_seen_next = 1'b0;
            conjunct_linker_seen_next    = 1'b0;
          end
        end
        CJ_EXTEND: begin
        end
        default: begin
          conjunct_consonant_seen_next = 1'b0;
          conjunct_linker_seen_next    = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_class          <= CL_OTHER;
      seen_any                <= 1'b0;
      regional_odd            <= 1'b0;
      pictograph_chain        <= 1'b0;
      conjunct_consonant_seen <= 1'b0;
      conjunct_linker_seen    <= 1'b0;
    end else if (step) begin
      previous_class          <= previous_class_next;
      seen_any                <= seen_any_next;
      regional_odd            <= regional_odd_next;
      pictograph_chain        <= pictograph_chain_next;
      conjunct_consonant_seen <= conjunct_consonant_seen_next;
      conjunct_linker_seen    <= conjunct_linker_seen_next;
    end
  end

`ifndef SYNTHESIS
  a_start_breaks: assert property (@(posedge clk) disable iff (rst)
    step && start_of_text |-> boundary)
    else $error("no boundary on start of text");

  a_seen_after_step: assert property (@(posedge clk) disable iff (rst)
    step |=> seen_any)
    else $error("seen_any not set after an item");

  a_linker_needs_consonant: assert property (@(posedge clk) disable iff (rst)
    conjunct_linker_seen |-> conjunct_consonant_seen)
    else $error("linker flag without consonant");

  a_ri_parity_prev: assert property (@(posedge clk) disable iff (rst)
    regional_odd |-> previous_class == CL_RI)
    else $error("regional parity set after non-RI class");
`endif

endmodule

/* design/grapheme_boundary_detector.sv */
// Path: each item passes through the input register, then the result register,
// before its result is presented.
// Throughput: one item per cycle unless the output stalls; the state loop in gbd_rules sets it.
// Reset: synchronous rst clears both valid flags and the rule state;
// start_of_text restarts the rule state ahead of its own item.
// ----------------------------------------------------------------------------
// grapheme_boundary_detector
// Extended grapheme cluster boundary detector, one code point per item.
// ----------------------------------------------------------------------------
module grapheme_boundary_detector import gbd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            start_of_text,
  input  logic [CP_W-1:0] code_point,
  input  logic            is_escape,
  input  logic [3:0]      break_class,
  input  logic [1:0]      conjunct_class,
  input  logic            pictographic,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            boundary_before
);

  logic            s1_valid;
  logic            s1_start;
  logic [CP_W-1:0] s1_code_point;
  logic            s1_escape;
  logic [3:0]      s1_break_class;
  logic [1:0]      s1_conjunct_class;
  logic            s1_pict;

  logic      advance;
  gbd_item_t item;
  logic      boundary;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_start          <= start_of_text;
      s1_code_point     <= code_point;
      s1_escape         <= is_escape;
      s1_break_class    <= break_class;
      s1_conjunct_class <= conjunct_class;
      s1_pict           <= pictographic;
    end
  end

  gbd_classify u_classify (
    .code_point     (s1_code_point),
    .is_escape      (s1_escape),
    .break_class    (s1_break_class),
    .conjunct_class (s1_conjunct_class),
    .pictographic   (s1_pict),
    .item           (item)
  );

  gbd_rules u_rules (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .start_of_text (s1_start),
    .item          (item),
    .boundary      (boundary)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      boundary_before <= boundary;
    end
  end

endmodule

/* dv/grapheme_boundary_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grapheme_boundary_checker
// Watches both channels of the grapheme boundary detector, predicts the
// boundary flag of every accepted code point and compares it in order with
// the flags that come out.
// ----------------------------------------------------------------------------
module grapheme_boundary_checker import gbd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_ready,
  input  logic            start_of_text,
  input  logic [CP_W-1:0] code_point,
  input  logic            is_escape,
  input  logic [3:0]      break_class,
  input  logic [1:0]      conjunct_class,
  input  logic            pictographic,
  input  logic            out_valid,
  input  logic            out_ready,
  input  logic            boundary_before,
  output int unsigned     fail_count,
  output int unsigned     pending,
  output int unsigned     results_checked,
  output int unsigned     boundary_count
);

  localparam int unsigned MAX_REPORTS = 40;

  typedef struct {
    int unsigned idx;
    logic        brk;
  } flag_entry_t;

  flag_entry_t expected_flags[$];
  int unsigned items_seen;

  // rule state of the predictor
  gb_class_t prev_cls;
  logic      seen_text;
  logic      ri_odd;
  logic      pict_chain;
  logic      cons_seen;
  logic      link_seen;

  function automatic void clear_text_state();
    prev_cls   = CL_OTHER;
    seen_text  = 1'b0;
    ri_odd     = 1'b0;
    pict_chain = 1'b0;
    cons_seen  = 1'b0;
    link_seen  = 1'b0;
  endfunction

  function automatic logic next_boundary(input logic sot, input logic [CP_W-1:0] cp,
                                         input logic esc, input logic [3:0] bc,
                                         input logic [1:0] cj_in, input logic pict_in);
    gb_class_t cur;
    cj_class_t cj;
    logic      pict;
    logic      brk;
    if (sot)
      clear_text_state();

    // printable ASCII right after an Other: always a boundary, class stays Other
    if (!esc && prev_cls == CL_OTHER && cp >= CP_CTRL_END && cp < CP_DEL) begin
      seen_text  = 1'b1;
      ri_odd     = 1'b0;
      pict_chain = 1'b0;
      cons_seen  = 1'b0;
      link_seen  = 1'b0;
      return 1'b1;
    end

    cj   = cj_class_t'(cj_in);
    pict = pict_in;
    if (esc) begin
      cur  = CL_CONTROL;
      cj   = CJ_NONE;
      pict = 1'b0;
    end else if (cp < CP_NON_ASCII) begin
      if (cp == CP_CR)
        cur = CL_CR;
      else if (cp == CP_LF)
        cur = CL_LF;
      else if (cp < CP_CTRL_END || cp == CP_DEL)
        cur = CL_CONTROL;
      else
        cur = CL_OTHER;
      cj   = CJ_NONE;
      pict = 1'b0;
    end else begin
      cur = (bc > 4'(CL_LVT)) ? CL_OTHER : gb_class_t'(bc);
    end

    if (!seen_text)
      brk = 1'b1;
    else if (prev_cls == CL_CR && cur == CL_LF)
      brk = 1'b0;
    else if (prev_cls inside {CL_CONTROL, CL_CR, CL_LF} ||
             cur inside {CL_CONTROL, CL_CR, CL_LF})
      brk = 1'b1;
    else if (prev_cls == CL_L && cur inside {CL_L, CL_V, CL_LV, CL_LVT})
      brk = 1'b0;
    else if (prev_cls inside {CL_LV, CL_V} && cur inside {CL_V, CL_T})
      brk = 1'b0;
    else if (prev_cls inside {CL_LVT, CL_T} && cur == CL_T)
      brk = 1'b0;
    else if (cur inside {CL_EXTEND, CL_ZWJ, CL_SPACINGMARK})
      brk = 1'b0;
    else if (prev_cls == CL_PREPEND)
      brk = 1'b0;
    else if (cj == CJ_CONSONANT && cons_seen && link_seen)
      brk = 1'b0;
    else if (prev_cls == CL_ZWJ && pict_chain && pict)
      brk = 1'b0;
    else if (cur == CL_RI && ri_odd)
      brk = 1'b0;
    else
      brk = 1'b1;

    ri_odd = (cur == CL_RI) ? !ri_odd : 1'b0;

    // Extend and ZWJ keep the pictograph chain alive, unless they follow a ZWJ
    if (pict)
      pict_chain = 1'b1;
    else if (!((cur == CL_EXTEND || cur == CL_ZWJ) && prev_cls != CL_ZWJ))
      pict_chain = 1'b0;

    if (cj == CJ_CONSONANT) begin
      cons_seen = 1'b1;
      link_seen = 1'b0;
    end else if (cj == CJ_LINKER && cons_seen) begin
      link_seen = 1'b1;
    end else if (cj != CJ_EXTEND) begin
      cons_seen = 1'b0;
      link_seen = 1'b0;
    end

    prev_cls  = cur;
    seen_text = 1'b1;
    return brk;
  endfunction

  always @(posedge clk) begin
    flag_entry_t head;
    flag_entry_t entry;
    if (rst) begin
      clear_text_state();
      expected_flags.delete();
      items_seen      = 0;
      fail_count      = 0;
      results_checked = 0;
      boundary_count  = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_flags.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual boundary_before=%0b",
                     $time, boundary_before);
        end else begin
          head = expected_flags.pop_front();
          results_checked++;
          if (boundary_before === 1'b1)
            boundary_count++;
          if (boundary_before !== head.brk) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: item %0d boundary_before expected %0b actual %0b",
                       $time, head.idx, head.brk, boundary_before);
          end
        end
      end
      if (in_valid && in_ready) begin
        entry.idx = items_seen;
        entry.brk = next_boundary(start_of_text, code_point, is_escape, break_class,
                                  conjunct_class, pictographic);
        expected_flags.push_back(entry);
        items_seen++;
      end
    end
    pending = expected_flags.size();
  end

endmodule

/* dv/grapheme_boundary_detector_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grapheme_boundary_detector_tb
// Feeds the boundary detector directed corner items and then well-formed
// grapheme clusters mixed with random noise, with bursty input, a stalling
// output side and one long output hold-off; the checker judges each flag.
// ----------------------------------------------------------------------------
module grapheme_boundary_detector_tb;
  import gbd_pkg::*;

  localparam int unsigned ITEM_TARGET = 1050;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef enum {RX_OPEN, RX_HALF, RX_SPARSE, RX_HOLD} rx_mode_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic            start_of_text = 1'b0;
  logic [CP_W-1:0] code_point = '0;
  logic            is_escape = 1'b0;
  logic [3:0]      break_class = '0;
  logic [1:0]      conjunct_class = '0;
  logic            pictographic = 1'b0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic            boundary_before;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_checked;
  int unsigned boundary_count;

  int unsigned items_sent = 0;
  int unsigned burst_left = 20;

  always #5 clk = ~clk;

  grapheme_boundary_detector u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .start_of_text  (start_of_text),
    .code_point     (code_point),
    .is_escape      (is_escape),
    .break_class    (break_class),
    .conjunct_class (conjunct_class),
    .pictographic   (pictographic),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .boundary_before(boundary_before)
  );

  grapheme_boundary_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .start_of_text  (start_of_text),
    .code_point     (code_point),
    .is_escape      (is_escape),
    .break_class    (break_class),
    .conjunct_class (conjunct_class),
    .pictographic   (pictographic),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .boundary_before(boundary_before),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_checked(results_checked),
    .boundary_count (boundary_count)
  );

  // offer one item; gaps fall between bursts of random length
  task automatic send_item(input logic sot, input logic [CP_W-1:0] cp, input logic esc,
                           input logic [3:0] bc, input logic [1:0] cj, input logic pict);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 12);
    end
    in_valid       <= 1'b1;
    start_of_text  <= sot;
    code_point     <= cp;
    is_escape      <= esc;
    break_class    <= bc;
    conjunct_class <= cj;
    pictographic   <= pict;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // non-ASCII code point whose properties come from the table fields
  task automatic send_table_cp(input gb_class_t bc, input cj_class_t cj, input logic pict);
    send_item(1'b0, CP_W'($urandom_range(32'h80, 32'h1F_FFFF)), 1'b0, bc, cj, pict);
  endtask

  task automatic send_random_cluster();
    int unsigned n;
    case ($urandom_range(0, 9))
      0: begin
        n = $urandom_range(1, 8);
        repeat (n)
          send_item(1'b0, CP_W'($urandom_range(32'h20, 32'h7E)), 1'b0,
                    4'($urandom()), 2'($urandom()), 1'($urandom()));
        if ($urandom_range(0, 1) == 1) begin
          send_item(1'b0, CP_CR, 1'b0, 4'($urandom()), 2'($urandom()), 1'($urandom()));
          send_item(1'b0, CP_LF, 1'b0, 4'($urandom()), 2'($urandom()), 1'($urandom()));
        end
      end
      1: begin
        n = $urandom_range(2, 6);
        repeat (n)
          send_table_cp(gb_class_t'($urandom_range(CL_L, CL_LVT)), CJ_NONE, 1'b0);
      end
      2: begin
        n = $urandom_range(1, 5);
        repeat (n) send_table_cp(CL_RI, CJ_NONE, 1'b0);
      end
      3: begin
        // pictograph, extends, ZWJ, usually a pictograph; sometimes a doubled ZWJ
        send_table_cp(CL_OTHER, CJ_NONE, 1'b1);
        n = $urandom_range(0, 2);
        repeat (n) send_table_cp(CL_EXTEND, CJ_EXTEND, 1'b0);
        send_table_cp(CL_ZWJ, CJ_EXTEND, 1'b0);
        if ($urandom_range(0, 4) == 0)
          send_table_cp(CL_ZWJ, CJ_EXTEND, 1'b0);
        send_table_cp(CL_OTHER, CJ_NONE, $urandom_range(0, 5) != 0);
      end
      4: begin
        // consonant, extends, linker, extends, consonant; linker sometimes missing
        send_table_cp(CL_OTHER, CJ_CONSONANT, 1'b0);
        n = $urandom_range(0, 2);
        repeat (n) send_table_cp(CL_EXTEND, CJ_EXTEND, 1'b0);
        if ($urandom_range(0, 4) != 0)
          send_table_cp(CL_EXTEND, CJ_LINKER, 1'b0);
        n = $urandom_range(0, 1);
        repeat (n) send_table_cp(CL_EXTEND, CJ_EXTEND, 1'b0);
        send_table_cp(CL_OTHER, CJ_CONSONANT, 1'b0);
      end
      5: begin
        send_table_cp(CL_PREPEND, CJ_NONE, 1'b0);
        send_table_cp(gb_class_t'($urandom_range(CL_OTHER, CL_LVT)),
                      cj_class_t'($urandom()), 1'($urandom()));
        send_table_cp($urandom_range(0, 1) ? CL_SPACINGMARK : CL_EXTEND, CJ_NONE, 1'b0);
      end
      6: begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: send_item(1'b0, CP_W'($urandom()), 1'b1, 4'($urandom()),
                         2'($urandom()), 1'($urandom()));
            1: send_item(1'b0, CP_W'($urandom_range(0, 32'h1F)), 1'b0, 4'($urandom()),
                         2'($urandom()), 1'($urandom()));
            2: send_item(1'b0, CP_CR, 1'b0, CL_OTHER, CJ_NONE, 1'b0);
            default: send_item(1'b0, CP_DEL, 1'b0, CL_OTHER, CJ_NONE, 1'b0);
          endcase
        end
      end
      9: send_item(1'b1, CP_W'($urandom()), 1'($urandom_range(0, 3) == 0),
                   4'($urandom()), 2'($urandom()), 1'($urandom()));
      default: begin
        n = $urandom_range(1, 6);
        repeat (n)
          send_item($urandom_range(0, 15) == 0,
                    $urandom_range(0, 2) == 0 ? CP_W'($urandom_range(0, 255))
                                              : CP_W'($urandom()),
                    $urandom_range(0, 3) == 0, 4'($urandom()), 2'($urandom()),
                    1'($urandom()));
      end
    endcase
  endtask

  // output side: stall pattern of its own, one long hold-off mid run
  initial begin : drain
    rx_mode_t    mode;
    int unsigned span;
    bit          held;
    held = 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(RX_OPEN, RX_SPARSE));
      span = $urandom_range(10, 60);
      if (!held && results_checked >= 300) begin
        held = 1'b1;
        mode = RX_HOLD;
        span = 120;
      end
      repeat (span) begin
        @(posedge clk);
        case (mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= 1'b0;
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
    $display("[grapheme_boundary_detector] ERROR");
    $finish;
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    send_item(1'b1, 21'h41, 1'b0, CL_OTHER, CJ_NONE, 1'b0);
    send_item(1'b0, CP_CTRL_END, 1'b0, CL_OTHER, CJ_NONE, 1'b0);
    send_item(1'b0, 21'h7E, 1'b0, CL_OTHER, CJ_NONE, 1'b0);
    send_item(1'b0, CP_DEL, 1'b0, CL_OTHER, CJ_NONE, 1'b0);
    send_item(1'b0, CP_CR, 1'b0, CL_OTHER, CJ_NONE, 1'b0);
    send_item(1'b0, CP_LF, 1'b0, CL_OTHER, CJ_NONE, 1'b0);
    send_item(1'b0, 21'h1F, 1'b0, CL_OTHER, CJ_NONE, 1'b0);
    send_item(1'b0, CP_NON_ASCII, 1'b0, CL_OTHER, CJ_NONE, 1'b0);
    send_item(1'b0, 21'h1F_FFFF, 1'b0, 4'hF, CJ_NONE, 1'b0);  // class beyond LVT
    send_item(1'b0, 21'h41, 1'b1, CL_EXTEND, CJ_LINKER, 1'b1); // escape over ASCII
    send_table_cp(CL_L, CJ_NONE, 1'b0);
    send_table_cp(CL_V, CJ_NONE, 1'b0);
    send_table_cp(CL_T, CJ_NONE, 1'b0);
    send_table_cp(CL_LVT, CJ_NONE, 1'b0);
    send_table_cp(CL_T, CJ_NONE, 1'b0);
    send_table_cp(CL_RI, CJ_NONE, 1'b0);
    send_table_cp(CL_RI, CJ_NONE, 1'b0);
    send_table_cp(CL_RI, CJ_NONE, 1'b0);
    send_table_cp(CL_OTHER, CJ_NONE, 1'b1);
    send_table_cp(CL_ZWJ, CJ_EXTEND, 1'b0);
    send_table_cp(CL_OTHER, CJ_NONE, 1'b1);
    send_table_cp(CL_PREPEND, CJ_NONE, 1'b0);
    send_table_cp(CL_OTHER, CJ_CONSONANT, 1'b0);
    send_table_cp(CL_EXTEND, CJ_LINKER, 1'b0);
    send_table_cp(CL_OTHER, CJ_CONSONANT, 1'b0);
    // ASCII ignores the table fields
    send_item(1'b0, 21'h5A, 1'b0, CL_SPACINGMARK, CJ_CONSONANT, 1'b1);

    while (items_sent < ITEM_TARGET)
      send_random_cluster();
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d code points; %0d flags checked, %0d of them boundaries.",
             items_sent, results_checked, boundary_count);
    $display("Covered ASCII paths, escapes, Hangul, RI pairs, emoji ZWJ and conjunct chains.");
    if (fail_count == 0)
      $display("[grapheme_boundary_detector] OK");
    else
      $display("[grapheme_boundary_detector] ERROR");
    $finish;
  end

endmodule
